[hw/rtl/dwtc_pkg.sv]
package dwtc_pkg;

   // Fixed field widths
   localparam int AddrW    = 16;
   localparam int DataW    = 8;
   localparam int CountW   = 32;
   localparam int PenaltyW = 8;

   // Defaults for the top-level parameters, and the fixed queue depth
   localparam int SlotCountDefault   = 16;
   localparam int MemoryBytesDefault = 65536;
   localparam int QueueDepth         = 2;

   localparam logic [PenaltyW-1:0] MissPenaltyReset = 8'd10;

   // Access kinds
   localparam logic ModeRead  = 1'b0;
   localparam logic ModeWrite = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [AddrW-1:0] address;
      logic [DataW-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DataW-1:0]  read_data;
      logic              hit;
      logic [CountW-1:0] hit_count;
      logic [CountW-1:0] miss_count;
      logic [CountW-1:0] cycle_count;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [AddrW-1:0] tag;
      logic [DataW-1:0] data;
   } slot_entry_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_EXEC
   } back_state_type;

endpackage

[hw/rtl/dwtc_queue.sv]
module dwtc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             push, pop;

   // Flag full and empty from the fill count
   assign push_ready = (count_ff != (AW+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;

   // Advance pointers, wrapping at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry on a push
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/dwtc_front.sv]
module dwtc_front #(
   parameter int SLOT_COUNT   = dwtc_pkg::SlotCountDefault,
   parameter int MEMORY_BYTES = dwtc_pkg::MemoryBytesDefault,
   localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
   localparam int MemW  = $clog2(MEMORY_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              hold,
   input  logic              req_valid,
   output logic              req_stall,
   input  dwtc_pkg::req_type req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output dwtc_pkg::req_type push_req,
   output logic [SlotW-1:0]  push_slot,
   output logic [MemW-1:0]   push_mem_idx
);
   import dwtc_pkg::*;

   localparam int ProdW = AddrW + 33;

   logic    a_valid_ff, a_valid_in;
   logic    b_valid_ff, b_valid_in;
   req_type a_req_ff, b_req_ff;
   logic    accept, a_go, b_go, a_free, b_free;

   // Two-stage pipe: stage A takes the transfer, stage B finishes the index math
   assign b_go      = b_valid_ff && push_ready;
   assign b_free    = !b_valid_ff || b_go;
   assign a_go      = a_valid_ff && b_free;
   assign a_free    = !a_valid_ff || a_go;
   assign req_stall = hold || !a_free;
   assign accept    = req_valid && !req_stall;

   assign push_valid = b_valid_ff;
   assign push_req   = b_req_ff;

   always_comb begin
      a_valid_in = accept ? 1'b1 : (a_go ? 1'b0 : a_valid_ff);
      b_valid_in = a_go ? 1'b1 : (b_go ? 1'b0 : b_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_req_ff <= req_data;
      end
      if (a_go) begin
         b_req_ff <= a_req_ff;
      end
   end

   // Slot index: address modulo slot count
   if (SLOT_COUNT == 1) begin : g_slot_one
      assign push_slot = '0;
   end else if ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0) begin : g_slot_pow2
      assign push_slot = b_req_ff.address[SlotW-1:0];
   end else begin : g_slot_recip
      localparam logic [32:0] SlotRecip = 33'((64'd1 << 32) / SLOT_COUNT + 1);
      logic [ProdW-1:0] prod;
      logic [AddrW-1:0] quot_ff, quot_in;
      logic [31:0]      rem;

      // Quotient by reciprocal in stage A, remainder in stage B
      assign prod    = ProdW'(a_req_ff.address) * ProdW'(SlotRecip);
      assign quot_in = prod[AddrW+31:32];
      always_ff @(posedge clock) begin
         if (a_go) begin
            quot_ff <= quot_in;
         end
      end
      assign rem       = 32'(b_req_ff.address) - 32'(quot_ff) * 32'(SLOT_COUNT);
      assign push_slot = rem[SlotW-1:0];
   end

   // Memory index: address modulo memory size
   if ((MEMORY_BYTES & (MEMORY_BYTES - 1)) == 0) begin : g_mem_pow2
      assign push_mem_idx = b_req_ff.address[MemW-1:0];
   end else begin : g_mem_recip
      localparam logic [32:0] MemRecip = 33'((64'd1 << 32) / MEMORY_BYTES + 1);
      logic [ProdW-1:0] prod;
      logic [AddrW-1:0] quot_ff, quot_in;
      logic [31:0]      rem;

      assign prod    = ProdW'(a_req_ff.address) * ProdW'(MemRecip);
      assign quot_in = prod[AddrW+31:32];
      always_ff @(posedge clock) begin
         if (a_go) begin
            quot_ff <= quot_in;
         end
      end
      assign rem          = 32'(b_req_ff.address) - 32'(quot_ff) * 32'(MEMORY_BYTES);
      assign push_mem_idx = rem[MemW-1:0];
   end

endmodule

[hw/rtl/dwtc_back.sv]
module dwtc_back #(
   parameter int SLOT_COUNT   = dwtc_pkg::SlotCountDefault,
   parameter int MEMORY_BYTES = dwtc_pkg::MemoryBytesDefault,
   localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
   localparam int MemW  = $clog2(MEMORY_BYTES)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [dwtc_pkg::PenaltyW-1:0]     penalty_cycles,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  dwtc_pkg::req_type                 pop_req,
   input  logic [SlotW-1:0]                  pop_slot,
   input  logic [MemW-1:0]                   pop_mem_idx,
   output logic                              clearing,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dwtc_pkg::rsp_type                 rsp_data
);
   import dwtc_pkg::*;

   localparam int ClearCount = (MEMORY_BYTES > SLOT_COUNT) ? MEMORY_BYTES : SLOT_COUNT;
   localparam int CW         = $clog2(ClearCount);
   localparam logic [CW-1:0] ClearLast = CW'(ClearCount - 1);

   back_state_type state_ff, state_in;
   logic [CW-1:0]  clear_idx_ff;

   // Memories
   logic [DataW-1:0] main_mem [MEMORY_BYTES];
   slot_entry_type   slot_mem [SLOT_COUNT];
   logic [DataW-1:0] mem_rd_ff;
   slot_entry_type   slot_rd_ff;

   // Item in flight
   req_type          cur_req_ff;
   logic [SlotW-1:0] cur_slot_ff;
   logic [MemW-1:0]  cur_mem_idx_ff;

   logic [CountW-1:0] hits_ff, hits_in;
   logic [CountW-1:0] misses_ff, misses_in;
   logic [CountW-1:0] cycles_ff, cycles_in;
   logic [CountW:0]   cycle_sum;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic pop, out_free, exec_go;
   logic is_write, match, read_hit, read_miss;

   logic             mem_we;
   logic [MemW-1:0]  mem_wa;
   logic [DataW-1:0] mem_wd;
   logic             slot_we;
   logic [SlotW-1:0] slot_wa;
   slot_entry_type   slot_wd;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = pop_ready && pop_valid;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_CLEAR: if (clear_idx_ff == ClearLast) state_in = BACK_IDLE;
         BACK_IDLE:  if (pop_valid) state_in = BACK_EXEC;
         BACK_EXEC:  if (out_free) state_in = BACK_IDLE;
         default:    state_in = BACK_CLEAR;
      endcase
   end

   // State outputs
   always_comb begin
      pop_ready = 1'b0;
      clearing  = 1'b0;
      exec_go   = 1'b0;
      case (state_ff)
         BACK_CLEAR: clearing = 1'b1;
         BACK_IDLE:  pop_ready = 1'b1;
         BACK_EXEC:  exec_go = out_free;
         default:    clearing = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_CLEAR;
         clear_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clear_idx_ff <= clear_idx_ff + 1'b1;
         end
      end
   end

   // Latch the popped item and issue both memory reads
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_req_ff     <= pop_req;
         cur_slot_ff    <= pop_slot;
         cur_mem_idx_ff <= pop_mem_idx;
         mem_rd_ff      <= main_mem[pop_mem_idx];
         slot_rd_ff     <= slot_mem[pop_slot];
      end
   end

   // Classify the access
   assign is_write  = (cur_req_ff.mode == ModeWrite);
   assign match     = slot_rd_ff.valid && (slot_rd_ff.tag == cur_req_ff.address);
   assign read_hit  = !is_write && match;
   assign read_miss = !is_write && !match;

   // Saturating counters; penalty joins the same add on a read miss
   always_comb begin
      cycle_sum = (CountW+1)'(cycles_ff) + (CountW+1)'(1)
                + (read_miss ? (CountW+1)'(penalty_cycles) : '0);
      cycles_in = cycle_sum[CountW] ? '1 : cycle_sum[CountW-1:0];
      hits_in   = (read_hit && hits_ff != '1) ? hits_ff + 1'b1 : hits_ff;
      misses_in = (read_miss && misses_ff != '1) ? misses_ff + 1'b1 : misses_ff;
   end

   always_comb begin
      rsp_in.read_data   = is_write ? '0 : (match ? slot_rd_ff.data : mem_rd_ff);
      rsp_in.hit         = match;
      rsp_in.hit_count   = hits_in;
      rsp_in.miss_count  = misses_in;
      rsp_in.cycle_count = cycles_in;
      rsp_valid_in       = exec_go ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff      <= '0;
         misses_ff    <= '0;
         cycles_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            hits_ff   <= hits_in;
            misses_ff <= misses_in;
            cycles_ff <= cycles_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Write ports: clearing sweep, else write-through and fills
   always_comb begin
      mem_we  = (clearing && (32'(clear_idx_ff) < MEMORY_BYTES)) || (exec_go && is_write);
      mem_wa  = clearing ? MemW'(clear_idx_ff) : cur_mem_idx_ff;
      mem_wd  = clearing ? '0 : cur_req_ff.write_data;
      slot_we = (clearing && (32'(clear_idx_ff) < SLOT_COUNT))
              || (exec_go && (read_miss || (is_write && match)));
      slot_wa = clearing ? SlotW'(clear_idx_ff) : cur_slot_ff;
      if (clearing) begin
         slot_wd = '0;
      end else begin
         slot_wd.valid = 1'b1;
         slot_wd.tag   = cur_req_ff.address;
         slot_wd.data  = is_write ? cur_req_ff.write_data : mem_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         main_mem[mem_wa] <= mem_wd;
      end
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
   end

endmodule

[hw/rtl/direct_mapped_write_through_cache_unit.sv]
// Direct-mapped write-through byte cache in front of an internal byte memory.
// Request channel (req_valid/req_stall/req_data): one access per transfer, a
// read or a write-through at a 16-bit address. Every access gives exactly one
// result on the response channel (rsp_valid/rsp_stall/rsp_data) in request
// order, carrying the read byte, the tag-hit flag and the saturating hit, miss
// and modeled-cycle counters. The csr channel writes the miss penalty; write
// it only while no access is outstanding. csr_ready is always high. A request
// passes front stages A and B, the queue and the back end's idle and execute
// states into the response register. The back end reads the tag and data
// memories on a pop and writes them in its execute state, popping nothing in
// between. Reset: counters and slot valid bits clear, miss penalty returns to
// 10. After reset a clearing pass zeroes the data memory and slot store over
// max(MEMORY_BYTES, SLOT_COUNT) entries (65536 by default); req_stall stays
// high through it. A stalled response holds in its output register while the
// front end and the two-entry queue keep taking requests until they fill.
module direct_mapped_write_through_cache_unit #(
   parameter int SLOT_COUNT   = dwtc_pkg::SlotCountDefault,
   parameter int MEMORY_BYTES = dwtc_pkg::MemoryBytesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dwtc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dwtc_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dwtc_pkg::PenaltyW-1:0] csr_data
);
   import dwtc_pkg::*;

   localparam int SlotW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int MemW   = $clog2(MEMORY_BYTES);
   localparam int ReqW   = $bits(req_type);
   localparam int EntryW = ReqW + SlotW + MemW;

   logic [PenaltyW-1:0] penalty_ff;
   logic                clearing;

   logic              push_valid, push_ready;
   req_type           push_req;
   logic [SlotW-1:0]  push_slot;
   logic [MemW-1:0]   push_mem_idx;
   logic [EntryW-1:0] push_entry, pop_entry;
   logic              pop_valid, pop_ready;
   req_type           pop_req;
   logic [SlotW-1:0]  pop_slot;
   logic [MemW-1:0]   pop_mem_idx;

   // Miss penalty register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         penalty_ff <= MissPenaltyReset;
      end else if (csr_valid && csr_ready) begin
         penalty_ff <= csr_data;
      end
   end

   dwtc_front #(
      .SLOT_COUNT   (SLOT_COUNT),
      .MEMORY_BYTES (MEMORY_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .hold         (clearing),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_req     (push_req),
      .push_slot    (push_slot),
      .push_mem_idx (push_mem_idx)
   );

   // Pack and unpack queue entries
   assign push_entry = {push_slot, push_mem_idx, push_req};
   assign pop_req     = pop_entry[ReqW-1:0];
   assign pop_mem_idx = pop_entry[ReqW+MemW-1:ReqW];
   assign pop_slot    = pop_entry[EntryW-1:ReqW+MemW];

   dwtc_queue #(
      .WIDTH (EntryW),
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_entry)
   );

   dwtc_back #(
      .SLOT_COUNT   (SLOT_COUNT),
      .MEMORY_BYTES (MEMORY_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .penalty_cycles (penalty_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_req        (pop_req),
      .pop_slot       (pop_slot),
      .pop_mem_idx    (pop_mem_idx),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

   // No request enters while the clearing pass runs
   assert property (@(posedge clock) disable iff (reset) clearing |-> req_stall)
      else $error("request accepted during clearing pass");

   // Nothing queued and no response pending during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !pop_valid && !rsp_valid)
      else $error("work in flight during clearing pass");

   // Cycle count strictly grows between back-to-back responses until saturated
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1 rsp_valid |->
         (rsp_data.cycle_count > $past(rsp_data.cycle_count))
         || (rsp_data.cycle_count == '1))
      else $error("cycle count did not advance");

endmodule

[tb/dwtc_access_checker.sv]
module dwtc_access_checker #(
   parameter int SLOT_COUNT   = dwtc_pkg::SlotCountDefault,
   parameter int MEMORY_BYTES = dwtc_pkg::MemoryBytesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  dwtc_pkg::req_type             req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  dwtc_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [dwtc_pkg::PenaltyW-1:0] csr_data,
   output int                            fail_count,
   output int                            checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import dwtc_pkg::*;

   // Shadow copy of the cache, the backing memory and the statistics
   logic [PenaltyW-1:0] penalty;
   logic                slot_valid [SLOT_COUNT];
   logic [AddrW-1:0]    slot_tag   [SLOT_COUNT];
   logic [DataW-1:0]    slot_byte  [SLOT_COUNT];
   logic [DataW-1:0]    mem_image  [MEMORY_BYTES];
   logic [CountW-1:0]   hits;
   logic [CountW-1:0]   misses;
   logic [CountW-1:0]   cycles;

   // Responses owed by the block, oldest first
   rsp_type pending_rsp [$];
   int      fails   = 0;
   int      checked = 0;

   function automatic logic [CountW-1:0] sat_add(logic [CountW-1:0] a, logic [CountW-1:0] b);
      logic [CountW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CountW] ? '1 : sum[CountW-1:0];
   endfunction

   // Apply one access to the shadow state and return the response it owes
   function automatic rsp_type predict_access(req_type acc);
      rsp_type     r;
      int unsigned slot;
      int unsigned idx;
      logic        match;
      slot  = acc.address % SLOT_COUNT;
      idx   = acc.address % MEMORY_BYTES;
      match = slot_valid[slot] && (slot_tag[slot] == acc.address);
      r     = '0;
      cycles = sat_add(cycles, 1);
      if (acc.mode == ModeWrite) begin
         // write-through: memory always, slot only on a tag match
         mem_image[idx] = acc.write_data;
         if (match) slot_byte[slot] = acc.write_data;
      end else if (match) begin
         hits        = sat_add(hits, 1);
         r.read_data = slot_byte[slot];
      end else begin
         // fill on read miss and pay the penalty
         misses           = sat_add(misses, 1);
         cycles           = sat_add(cycles, CountW'(penalty));
         r.read_data      = mem_image[idx];
         slot_valid[slot] = 1'b1;
         slot_tag[slot]   = acc.address;
         slot_byte[slot]  = mem_image[idx];
      end
      r.hit         = match;
      r.hit_count   = hits;
      r.miss_count  = misses;
      r.cycle_count = cycles;
      return r;
   endfunction

   task automatic check_field(string name, logic [CountW-1:0] want, logic [CountW-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         penalty = MissPenaltyReset;
         foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_tag[i]   = '0;
            slot_byte[i]  = '0;
         end
         foreach (mem_image[i]) mem_image[i] = '0;
         hits   = '0;
         misses = '0;
         cycles = '0;
         pending_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) penalty = csr_data;
         // compare each response transfer with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            seen = rsp_data;
            if (pending_rsp.size() == 0) begin
               $error("response transfer with no access outstanding");
               fails++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("read_data", CountW'(want.read_data), CountW'(seen.read_data));
               check_field("hit", CountW'(want.hit), CountW'(seen.hit));
               check_field("hit_count", want.hit_count, seen.hit_count);
               check_field("miss_count", want.miss_count, seen.miss_count);
               check_field("cycle_count", want.cycle_count, seen.cycle_count);
            end
            checked++;
         end
         if (req_valid && !req_stall) pending_rsp.push_back(predict_access(req_data));
      end
      fail_count    <= fails;
      checked_count <= checked;
   end

endmodule

[tb/tb_direct_mapped_write_through_cache_unit.sv]
module tb_direct_mapped_write_through_cache_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import dwtc_pkg::*;

   // Clearing pass plus every access at its worst gap and stall, with room to spare
   localparam int CycleLimit   = 1000000;
   localparam int PhaseItems   = 432;
   localparam int DrainCycles  = 8;
   localparam int PoolSize     = 24;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [PenaltyW-1:0] csr_data;

   int fail_count;
   int checked_count;
   int issued    = 0;
   int cycle_num = 0;
   bit req_calm  = 1'b0;
   bit rsp_calm  = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   direct_mapped_write_through_cache_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   dwtc_access_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .checked_count (checked_count)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_num <= cycle_num + 1;
      if (cycle_num >= CycleLimit) begin
         $display("[direct_mapped_write_through_cache_unit] ERROR");
         $finish;
      end
   end

   // Response side: hold stall for a drawn number of cycles per transfer
   initial begin
      int unsigned hold;
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
         hold = rsp_calm ? 0 : $urandom_range(0, 8);
         rsp_stall <= (hold != 0);
         if (hold != 0) begin
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic req_type make_access(logic mode, logic [AddrW-1:0] addr,
                                           logic [DataW-1:0] data);
      req_type acc;
      acc.mode       = mode;
      acc.address    = addr;
      acc.write_data = data;
      return acc;
   endfunction

   // Offer one access after a drawn gap and hold it until the transfer
   task automatic issue_access(req_type acc);
      int unsigned gap;
      if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= acc;
      do @(posedge clock); while (req_stall);
      issued++;
   endtask

   // Drop valid and wait until every access has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (checked_count < issued) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_penalty(logic [PenaltyW-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly accesses to a small set of addresses that share slots, so reads
   // hit, miss and evict each other; the rest spread over the whole space
   task automatic run_mixed_phase(int unsigned n_items);
      logic [AddrW-1:0] pool [PoolSize];
      logic [AddrW-1:0] tag_part;
      int unsigned      slot_pick;
      req_type          acc;
      slot_pick = 0;
      foreach (pool[i]) begin
         if (i % 4 == 0) slot_pick = $urandom_range(0, SlotCountDefault - 1);
         tag_part = AddrW'($urandom);
         pool[i]  = AddrW'(32'(tag_part) - (32'(tag_part) % SlotCountDefault) + slot_pick);
      end
      repeat (n_items) begin
         acc.mode       = ($urandom_range(0, 9) < 4) ? ModeWrite : ModeRead;
         acc.address    = ($urandom_range(0, 3) == 0) ? AddrW'($urandom)
                                                      : pool[$urandom_range(0, PoolSize - 1)];
         acc.write_data = DataW'($urandom);
         issue_access(acc);
      end
      drain_results();
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed accesses with the reset penalty
      issue_access(make_access(ModeRead,  16'h0000, 8'h00));  // cold miss, zero memory
      issue_access(make_access(ModeRead,  16'h0000, 8'hFF));  // hit, data ignored
      issue_access(make_access(ModeWrite, 16'hFFFF, 8'hFF));  // write with no tag match
      issue_access(make_access(ModeRead,  16'hFFFF, 8'h00));  // miss fetches written byte
      issue_access(make_access(ModeRead,  16'hFFFF, 8'h00));  // hit
      issue_access(make_access(ModeWrite, 16'hFFFF, 8'h00));  // write hit updates slot
      issue_access(make_access(ModeRead,  16'hFFFF, 8'h00));  // hit sees new byte
      issue_access(make_access(ModeRead,  16'h000F, 8'h00));  // same slot, other tag
      issue_access(make_access(ModeRead,  16'hFFFF, 8'h00));  // evicted, miss again
      issue_access(make_access(ModeWrite, 16'h0010, 8'h5A));  // aliases slot 0, no update
      issue_access(make_access(ModeRead,  16'h0000, 8'h00));  // slot 0 still holds old tag
      issue_access(make_access(ModeRead,  16'h0010, 8'h00));
      issue_access(make_access(ModeWrite, 16'h0010, 8'hA5));
      issue_access(make_access(ModeRead,  16'h0010, 8'h00));
      issue_access(make_access(ModeWrite, 16'h8000, 8'hC3));
      issue_access(make_access(ModeRead,  16'h8000, 8'h00));
      issue_access(make_access(ModeRead,  16'h7FFF, 8'h00));
      issue_access(make_access(ModeWrite, 16'h5555, 8'hAA));
      issue_access(make_access(ModeRead,  16'h5555, 8'h00));
      issue_access(make_access(ModeWrite, 16'hAAAA, 8'h55));
      issue_access(make_access(ModeRead,  16'hAAAA, 8'h00));
      drain_results();

      // Random phases across penalty settings, extremes included
      write_penalty('0);
      run_mixed_phase(PhaseItems);
      write_penalty('1);
      run_mixed_phase(PhaseItems);
      write_penalty(PenaltyW'($urandom_range(2, 254)));
      run_mixed_phase(PhaseItems);
      write_penalty(PenaltyW'(1));
      run_mixed_phase(PhaseItems);

      if (fail_count == 0) begin
         $display("[direct_mapped_write_through_cache_unit] OK");
      end else begin
         $display("[direct_mapped_write_through_cache_unit] ERROR");
      end
      $finish;
   end

endmodule
